[hw/rtl/heater_step_controller_macros.svh]
// assertion macros for the heater step controller
// needs clk_i and rst_ni in the scope of the module that uses them
`ifndef HEATER_STEP_CONTROLLER_MACROS_SVH
`define HEATER_STEP_CONTROLLER_MACROS_SVH

// checked only outside reset
`define HSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define HSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hw/rtl/hsc_pkg.sv]
// shared types and constants for the heater step controller
// no dependencies
package hsc_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned TEMP_W = 15;
  localparam int unsigned PWR_W  = 7;
  localparam int unsigned CIDX_W = 3;
  localparam int unsigned CDAT_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_SAMPLE = 3'd1,
    OP_START  = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4,
    OP_FINISH = 3'd5,
    OP_CANCEL = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_TRIP    = 2'd1,
    EV_HOLD    = 2'd2,
    EV_REFUSED = 2'd3
  } ev_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_TARGET_TEMP = 3'd0,
    REG_SAFE_LIMIT  = 3'd1,
    REG_PULSE_GAP   = 3'd2,
    REG_ZERO_PULSES = 3'd3,
    REG_HOLD_TICKS  = 3'd4
  } reg_e;

  localparam logic [6:0]  TARGET_TEMP_RST = 7'd60;
  localparam logic [9:0]  SAFE_LIMIT_RST  = 10'd100;
  localparam logic [15:0] PULSE_GAP_RST   = 16'd300;
  localparam logic [7:0]  ZERO_PULSES_RST = 8'd100;
  localparam logic [15:0] HOLD_TICKS_RST  = 16'd20000;

  // band edges in 1/16 degree: 10, 5 and 2 degrees
  localparam logic signed [16:0] BAND_HI_DIFF  = 17'sd160;
  localparam logic signed [16:0] BAND_MID_DIFF = 17'sd80;
  localparam logic signed [16:0] BAND_LO_DIFF  = 17'sd32;

  localparam logic [PWR_W-1:0] PWR_MAX  = 7'd100;
  localparam logic [PWR_W-1:0] PWR_HI   = 7'd100;
  localparam logic [PWR_W-1:0] PWR_MID  = 7'd70;
  localparam logic [PWR_W-1:0] PWR_LO   = 7'd40;
  localparam logic [PWR_W-1:0] PWR_MIN  = 7'd20;

  typedef struct packed {
    logic [6:0]  target_temp;
    logic [9:0]  safe_limit;
    logic [15:0] pulse_gap;
    logic [7:0]  zero_pulses;
    logic [15:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [TEMP_W-1:0] chamber_temp;
    logic              chamber_valid;
    logic [TEMP_W-1:0] hot_temp;
    logic              hot_valid;
  } item_t;

  typedef struct packed {
    logic             step_up;
    logic             step_down;
    logic [PWR_W-1:0] power_level;
    logic [PWR_W-1:0] power_aim;
    logic             heating;
    logic             zeroing;
    ev_e              event_code;
  } res_t;

endpackage

[hw/rtl/hsc_cfg_regs.sv]
// configuration registers of the heater step controller
// depends on hsc_pkg
module hsc_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hsc_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [hsc_pkg::CDAT_W-1:0] cfg_data_i,
  output hsc_pkg::cfg_t              cfg_o
);

  hsc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (hsc_pkg::reg_e'(cfg_idx_i))
        hsc_pkg::REG_TARGET_TEMP: cfg_d.target_temp = cfg_data_i[6:0];
        hsc_pkg::REG_SAFE_LIMIT:  cfg_d.safe_limit  = cfg_data_i[9:0];
        hsc_pkg::REG_PULSE_GAP:   cfg_d.pulse_gap   = cfg_data_i;
        hsc_pkg::REG_ZERO_PULSES: cfg_d.zero_pulses = cfg_data_i[7:0];
        hsc_pkg::REG_HOLD_TICKS:  cfg_d.hold_ticks  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp <= hsc_pkg::TARGET_TEMP_RST;
      cfg_q.safe_limit  <= hsc_pkg::SAFE_LIMIT_RST;
      cfg_q.pulse_gap   <= hsc_pkg::PULSE_GAP_RST;
      cfg_q.zero_pulses <= hsc_pkg::ZERO_PULSES_RST;
      cfg_q.hold_ticks  <= hsc_pkg::HOLD_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/hsc_core.sv]
// controller state and the per-item update logic
// depends on hsc_pkg
module hsc_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  hsc_pkg::item_t item_i,
  input  hsc_pkg::cfg_t  cfg_i,
  output hsc_pkg::res_t  res_o
);

  logic [hsc_pkg::PWR_W-1:0] pwr_now_q, pwr_now_d, pwr_goal_q, pwr_goal_d;
  logic [7:0]  zero_left_q, zero_left_d;
  logic [15:0] gap_q, gap_d, hold_q, hold_d;
  logic        zero_act_q, zero_act_d, reached_q, reached_d;
  logic        run_q, run_d, paused_q, paused_d;

  logic        up, dn, zreq, trip;
  logic [15:0] gap_inc, hold_inc;
  logic signed [15:0] hot_s, limit_s;
  logic signed [16:0] diff;
  hsc_pkg::ev_e ev;

  assign hot_s   = 16'(signed'(item_i.hot_temp));
  assign limit_s = signed'({2'b00, cfg_i.safe_limit, 4'b0000});
  assign diff    = signed'({6'b0, cfg_i.target_temp, 4'b0000})
                 - 17'(signed'(item_i.chamber_temp));
  assign trip    = item_i.hot_valid && (hot_s >= limit_s);
  assign gap_inc = (gap_q == 16'hffff) ? gap_q : gap_q + 16'd1;
  assign hold_inc = (hold_q == 16'hffff) ? hold_q : hold_q + 16'd1;

  always_comb begin
    pwr_now_d   = pwr_now_q;
    pwr_goal_d  = pwr_goal_q;
    zero_left_d = zero_left_q;
    gap_d       = gap_q;
    hold_d      = hold_q;
    zero_act_d  = zero_act_q;
    reached_d   = reached_q;
    run_d       = run_q;
    paused_d    = paused_q;
    up          = 1'b0;
    dn          = 1'b0;
    zreq        = 1'b0;
    ev          = hsc_pkg::EV_NONE;

    unique case (hsc_pkg::op_e'(item_i.operation))
      hsc_pkg::OP_TICK: begin
        gap_d = gap_inc;
        if (zero_act_q) begin
          if (gap_inc >= cfg_i.pulse_gap) begin
            gap_d = '0;
            if (zero_left_q != 8'd0) begin
              dn          = 1'b1;
              zero_left_d = zero_left_q - 8'd1;
              pwr_now_d   = '0;
            end
            if (zero_left_d == 8'd0) begin
              zero_act_d = 1'b0;
              pwr_now_d  = '0;
              pwr_goal_d = '0;
            end
          end
        end else if (pwr_now_q != pwr_goal_q && gap_inc >= cfg_i.pulse_gap) begin
          gap_d = '0;
          if (pwr_now_q < pwr_goal_q) begin
            if (pwr_now_q < hsc_pkg::PWR_MAX) begin
              up        = 1'b1;
              pwr_now_d = pwr_now_q + 7'd1;
            end
          end else if (pwr_now_q != '0) begin
            dn        = 1'b1;
            pwr_now_d = pwr_now_q - 7'd1;
          end
        end
        if (run_q && reached_q) begin
          pwr_goal_d = '0;
          hold_d     = hold_inc;
          if (hold_inc >= cfg_i.hold_ticks) begin
            run_d = 1'b0;
            zreq  = 1'b1;
            ev    = hsc_pkg::EV_HOLD;
          end
        end
      end
      hsc_pkg::OP_SAMPLE: begin
        if (run_q) begin
          if (trip) begin
            run_d      = 1'b0;
            paused_d   = 1'b0;
            reached_d  = 1'b0;
            hold_d     = '0;
            pwr_goal_d = '0;
            zreq       = 1'b1;
            ev         = hsc_pkg::EV_TRIP;
          end else if (item_i.chamber_valid) begin
            if (diff <= 17'sd0) begin
              if (!reached_q) begin
                reached_d = 1'b1;
                hold_d    = '0;
              end
              pwr_goal_d = '0;
            end else begin
              reached_d = 1'b0;
              hold_d    = '0;
              if (diff >= hsc_pkg::BAND_HI_DIFF) begin
                pwr_goal_d = hsc_pkg::PWR_HI;
              end else if (diff >= hsc_pkg::BAND_MID_DIFF) begin
                pwr_goal_d = hsc_pkg::PWR_MID;
              end else if (diff >= hsc_pkg::BAND_LO_DIFF) begin
                pwr_goal_d = hsc_pkg::PWR_LO;
              end else begin
                pwr_goal_d = hsc_pkg::PWR_MIN;
              end
            end
          end
        end
      end
      hsc_pkg::OP_START: begin
        if (zero_act_q) begin
          ev = hsc_pkg::EV_REFUSED;
        end else if (!run_q) begin
          run_d      = 1'b1;
          paused_d   = 1'b0;
          pwr_now_d  = '0;
          pwr_goal_d = '0;
          reached_d  = 1'b0;
          hold_d     = '0;
        end
      end
      hsc_pkg::OP_PAUSE: begin
        if (run_q) begin
          run_d      = 1'b0;
          paused_d   = 1'b1;
          pwr_goal_d = pwr_now_q;
        end
      end
      hsc_pkg::OP_RESUME: begin
        if (paused_q) begin
          paused_d = 1'b0;
          run_d    = 1'b1;
        end
      end
      hsc_pkg::OP_FINISH: begin
        if (run_q) begin
          run_d      = 1'b0;
          pwr_goal_d = '0;
        end
      end
      hsc_pkg::OP_CANCEL: begin
        if (paused_q) begin
          paused_d   = 1'b0;
          pwr_goal_d = '0;
          zreq       = 1'b1;
        end
      end
      default: ;
    endcase

    // a zeroing run already under way is left alone
    if (zreq && !zero_act_d) begin
      zero_act_d  = 1'b1;
      zero_left_d = cfg_i.zero_pulses;
      pwr_goal_d  = '0;
      gap_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwr_now_q   <= '0;
      pwr_goal_q  <= '0;
      zero_left_q <= '0;
      gap_q       <= '0;
      hold_q      <= '0;
      zero_act_q  <= 1'b0;
      reached_q   <= 1'b0;
      run_q       <= 1'b0;
      paused_q    <= 1'b0;
    end else if (adv_i) begin
      pwr_now_q   <= pwr_now_d;
      pwr_goal_q  <= pwr_goal_d;
      zero_left_q <= zero_left_d;
      gap_q       <= gap_d;
      hold_q      <= hold_d;
      zero_act_q  <= zero_act_d;
      reached_q   <= reached_d;
      run_q       <= run_d;
      paused_q    <= paused_d;
    end
  end

  always_comb begin
    res_o.step_up     = up;
    res_o.step_down   = dn;
    res_o.power_level = pwr_now_d;
    res_o.power_aim   = pwr_goal_d;
    res_o.heating     = run_d;
    res_o.zeroing     = zero_act_d;
    res_o.event_code  = ev;
  end

endmodule

[hw/rtl/heater_step_controller.sv]
// heater step controller top level: input register, core and result register
// depends on hsc_pkg, hsc_cfg_regs, hsc_core and heater_step_controller_macros.svh
//
// Each input transfer carries one item: a tick, a temperature sample or a user
// command (start, pause, resume, finish, cancel). Every item yields exactly one
// result transfer with the knob pulse for that item, the believed and aimed
// power, the run and zeroing flags and an event code.
// The item is caught in an input register, updated against the controller
// state by one combinational pass and written to the result register, so
// out_valid_o rises once the result register is written, which waits while
// the receiver stalls. One item per cycle is sustained while the receiver
// takes every result; the state update of one pass feeds the next directly.
// When the receiver stalls, the result register holds its contents and the
// input register takes one more item; after that in_ready_o drops until the
// result is taken.
// The user writes registers through cfg_we_i, cfg_idx_i and cfg_data_i only
// while the block is idle, which the block does not enforce; a write takes
// effect on the next edge. Reset clears both valid flags and all controller
// state and loads the register defaults: target 60 C, trip 100 C, pulse gap
// 300, 100 zeroing pulses and a hold of 20000 ticks.
`include "heater_step_controller_macros.svh"

module heater_step_controller (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hsc_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [hsc_pkg::CDAT_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 operation_i,
  input  logic signed [14:0]         chamber_temp_i,
  input  logic                       chamber_valid_i,
  input  logic signed [14:0]         hot_temp_i,
  input  logic                       hot_valid_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       step_up_o,
  output logic                       step_down_o,
  output logic [6:0]                 power_level_o,
  output logic [6:0]                 power_aim_o,
  output logic                       heating_o,
  output logic                       zeroing_o,
  output logic [1:0]                 event_code_o
);

  hsc_pkg::cfg_t  cfg;
  hsc_pkg::item_t item_q;
  hsc_pkg::res_t  res, res_q;
  logic           in_vld_q, in_vld_d, out_vld_q, out_vld_d, adv, in_xfer;

  hsc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hsc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.operation     <= operation_i;
      item_q.chamber_temp  <= chamber_temp_i;
      item_q.chamber_valid <= chamber_valid_i;
      item_q.hot_temp      <= hot_temp_i;
      item_q.hot_valid     <= hot_valid_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign step_up_o     = res_q.step_up;
  assign step_down_o   = res_q.step_down;
  assign power_level_o = res_q.power_level;
  assign power_aim_o   = res_q.power_aim;
  assign heating_o     = res_q.heating;
  assign zeroing_o     = res_q.zeroing;
  assign event_code_o  = res_q.event_code;

  `HSC_ASSERT_ALWAYS(a_stall_only_when_full,
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i), "input stalled with room")
  `HSC_ASSERT(a_one_pulse,
    out_vld_q |-> !(res_q.step_up && res_q.step_down), "both knob pulses in one result")
  `HSC_ASSERT(a_zero_not_run,
    out_vld_q && res_q.zeroing |-> !res_q.heating, "zeroing during a heating run")
  `HSC_ASSERT(a_power_range,
    out_vld_q |-> (res_q.power_level <= hsc_pkg::PWR_MAX
                   && res_q.power_aim <= hsc_pkg::PWR_MAX), "power beyond full scale")
  `HSC_ASSERT(a_result_follows, $past(adv) |-> out_vld_q, "processed item gave no result")

endmodule
